// File: src/spc_pkg.sv
// Shared types and constants for the spring constraint projection block.
`timescale 1ns / 1ps

package spc_pkg;

    // 2^32 / sqrt(2), rounded to nearest
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sqrt_load;
        logic sqrt_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage

// File: src/spc_spring_if.sv
// Input channel: one spring word (endpoints and rest length).
`timescale 1ns / 1ps

interface spc_spring_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] end_a_x;
    logic signed [COORD_WIDTH-1:0] end_a_y;
    logic signed [COORD_WIDTH-1:0] end_b_x;
    logic signed [COORD_WIDTH-1:0] end_b_y;
    logic        [COORD_WIDTH-2:0] rest_length;

    modport source (
        output valid, end_a_x, end_a_y, end_b_x, end_b_y, rest_length,
        input  ready
    );

    modport sink (
        input  valid, end_a_x, end_a_y, end_b_x, end_b_y, rest_length,
        output ready
    );
endinterface

// File: src/spc_proj_if.sv
// Output channel: one projection word per spring.
`timescale 1ns / 1ps

interface spc_proj_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] proj_dx;
    logic signed [COORD_WIDTH-1:0] proj_dy;
    logic        [COORD_WIDTH:0]   spring_length;
    logic        [COORD_WIDTH:0]   shortest_length;
    logic                          zero_length;

    modport source (
        output valid, proj_dx, proj_dy, spring_length, shortest_length, zero_length,
        input  ready
    );

    modport sink (
        input  valid, proj_dx, proj_dy, spring_length, shortest_length, zero_length,
        output ready
    );
endinterface

// File: src/spc_datapath.sv
// Datapath: shift-add multipliers, bit-serial square root, restoring dividers.
`timescale 1ns / 1ps

module spc_datapath #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spc_pkg::t_cmd                 i_cmd,
    input  logic signed [COORD_WIDTH-1:0] i_end_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_b_y,
    input  logic        [COORD_WIDTH-2:0] i_rest_length,
    output logic signed [COORD_WIDTH-1:0] o_proj_dx,
    output logic signed [COORD_WIDTH-1:0] o_proj_dy,
    output logic        [COORD_WIDTH:0]   o_spring_length,
    output logic        [COORD_WIDTH:0]   o_shortest_length,
    output logic                          o_zero_length
);
    import spc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int N   = W + 1;
    localparam int RW  = W - 1;
    localparam int SW  = 2 * N;
    localparam int PW  = 2 * W;
    localparam int SRW = W + 2;

    logic [N-1:0]   dx_c, dy_c, mx_c, my_c;

    logic [N-1:0]   r_mx, r_my, n_mx, n_my;
    logic           r_nx, r_ny, n_nx, n_ny;
    logic [RW-1:0]  r_rest, n_rest;
    logic [SW-1:0]  r_psx, r_psy, n_psx, n_psy;
    logic [PW-1:0]  r_prx, r_pry, n_prx, n_pry;
    logic [SW-1:0]  r_sum, n_sum;
    logic [SRW-1:0] r_srem, n_srem;
    logic [N-1:0]   r_root, n_root;
    logic [N-1:0]   r_drx, r_dry, n_drx, n_dry;
    logic [RW-1:0]  r_qx, r_qy, n_qx, n_qy;
    logic [RW-1:0]  r_fb, n_fb;
    logic [N-1:0]   r_min, n_min;

    logic [W-1:0]   r_out_dx, r_out_dy, n_out_dx, n_out_dy;
    logic [N-1:0]   r_out_len, r_out_short, n_out_len, n_out_short;
    logic           r_out_zero, n_out_zero;

    logic [N:0]     sqx_sum, sqy_sum;
    logic [W-1:0]   rx_sum, ry_sum;
    logic [SRW+1:0] sq_t, sq_trial, sq_diff;
    logic           sq_ge;
    logic [N:0]     dv_tx, dv_ty, dv_d, dv_diffx, dv_diffy;
    logic           dv_gex, dv_gey;
    logic [W+30:0]  fb_prod;
    logic           len_zero;

    assign dx_c = {i_end_b_x[W-1], i_end_b_x} - {i_end_a_x[W-1], i_end_a_x};
    assign dy_c = {i_end_b_y[W-1], i_end_b_y} - {i_end_a_y[W-1], i_end_a_y};
    assign mx_c = dx_c[N-1] ? (~dx_c + 1'b1) : dx_c;
    assign my_c = dy_c[N-1] ? (~dy_c + 1'b1) : dy_c;

    assign sqx_sum = {1'b0, r_psx[SW-1:N]} + (r_psx[0] ? {1'b0, r_mx} : '0);
    assign sqy_sum = {1'b0, r_psy[SW-1:N]} + (r_psy[0] ? {1'b0, r_my} : '0);
    assign rx_sum  = {1'b0, r_prx[PW-1:N]} + (r_prx[0] ? {1'b0, r_rest} : '0);
    assign ry_sum  = {1'b0, r_pry[PW-1:N]} + (r_pry[0] ? {1'b0, r_rest} : '0);

    assign sq_t     = {r_srem, r_sum[SW-1:SW-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);
    assign sq_diff  = sq_t - sq_trial;

    assign dv_d     = {1'b0, r_root};
    assign dv_tx    = {r_drx, r_qx[RW-1]};
    assign dv_ty    = {r_dry, r_qy[RW-1]};
    assign dv_gex   = (dv_tx >= dv_d);
    assign dv_gey   = (dv_ty >= dv_d);
    assign dv_diffx = dv_tx - dv_d;
    assign dv_diffy = dv_ty - dv_d;

    assign fb_prod  = {{32{1'b0}}, r_rest} * {{RW{1'b0}}, INV_SQRT2_Q32};
    assign len_zero = (r_root == '0);

    always_comb begin
        n_mx        = r_mx;
        n_my        = r_my;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_rest      = r_rest;
        n_psx       = r_psx;
        n_psy       = r_psy;
        n_prx       = r_prx;
        n_pry       = r_pry;
        n_sum       = r_sum;
        n_srem      = r_srem;
        n_root      = r_root;
        n_drx       = r_drx;
        n_dry       = r_dry;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_fb        = r_fb;
        n_min       = r_min;
        n_out_dx    = r_out_dx;
        n_out_dy    = r_out_dy;
        n_out_len   = r_out_len;
        n_out_short = r_out_short;
        n_out_zero  = r_out_zero;

        if (i_cmd.load) begin
            n_mx   = mx_c;
            n_my   = my_c;
            n_nx   = dx_c[N-1];
            n_ny   = dy_c[N-1];
            n_rest = i_rest_length;
            n_psx  = {{N{1'b0}}, mx_c};
            n_psy  = {{N{1'b0}}, my_c};
            n_prx  = {{RW{1'b0}}, mx_c};
            n_pry  = {{RW{1'b0}}, my_c};
        end
        if (i_cmd.mul_step) begin
            n_psx = {sqx_sum, r_psx[N-1:1]};
            n_psy = {sqy_sum, r_psy[N-1:1]};
            n_prx = {rx_sum, r_prx[N-1:1]};
            n_pry = {ry_sum, r_pry[N-1:1]};
        end
        if (i_cmd.sqrt_load) begin
            n_sum  = r_psx + r_psy;
            n_srem = '0;
            n_root = '0;
        end
        if (i_cmd.sqrt_step) begin
            n_sum  = {r_sum[SW-3:0], 2'b00};
            n_srem = sq_ge ? sq_diff[SRW-1:0] : sq_t[SRW-1:0];
            n_root = {r_root[N-2:0], sq_ge};
        end
        if (i_cmd.div_load) begin
            n_drx = r_prx[PW-1:RW];
            n_dry = r_pry[PW-1:RW];
            n_qx  = r_prx[RW-1:0];
            n_qy  = r_pry[RW-1:0];
            n_fb  = fb_prod[W+30:32];
        end
        if (i_cmd.div_step) begin
            n_drx = dv_gex ? dv_diffx[N-1:0] : dv_tx[N-1:0];
            n_dry = dv_gey ? dv_diffy[N-1:0] : dv_ty[N-1:0];
            n_qx  = {r_qx[RW-2:0], dv_gex};
            n_qy  = {r_qy[RW-2:0], dv_gey};
        end
        if (i_cmd.out_load) begin
            if (r_root < r_min) begin
                n_min = r_root;
            end
            n_out_short = n_min;
            n_out_len   = r_root;
            n_out_zero  = len_zero;
            if (len_zero) begin
                n_out_dx = {1'b0, r_fb};
                n_out_dy = {1'b0, r_fb};
            end else begin
                n_out_dx = r_nx ? (~{1'b0, r_qx} + 1'b1) : {1'b0, r_qx};
                n_out_dy = r_ny ? (~{1'b0, r_qy} + 1'b1) : {1'b0, r_qy};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
        end else begin
            r_min <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx        <= n_mx;
        r_my        <= n_my;
        r_nx        <= n_nx;
        r_ny        <= n_ny;
        r_rest      <= n_rest;
        r_psx       <= n_psx;
        r_psy       <= n_psy;
        r_prx       <= n_prx;
        r_pry       <= n_pry;
        r_sum       <= n_sum;
        r_srem      <= n_srem;
        r_root      <= n_root;
        r_drx       <= n_drx;
        r_dry       <= n_dry;
        r_qx        <= n_qx;
        r_qy        <= n_qy;
        r_fb        <= n_fb;
        r_out_dx    <= n_out_dx;
        r_out_dy    <= n_out_dy;
        r_out_len   <= n_out_len;
        r_out_short <= n_out_short;
        r_out_zero  <= n_out_zero;
    end

    assign o_proj_dx         = r_out_dx;
    assign o_proj_dy         = r_out_dy;
    assign o_spring_length   = r_out_len;
    assign o_shortest_length = r_out_short;
    assign o_zero_length     = r_out_zero;

endmodule

// File: src/spc_ctrl.sv
// Controller: sequences multiply, square root, divide and result hand-off.
`timescale 1ns / 1ps

module spc_ctrl #(
    parameter int COORD_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output spc_pkg::t_cmd o_cmd
);
    import spc_pkg::*;

    localparam int N  = COORD_WIDTH + 1;
    localparam int CW = $clog2(N);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          mul_last, div_last, out_free;

    assign mul_last = (r_cnt == CW'(N - 1));
    assign div_last = (r_cnt == CW'(COORD_WIDTH - 2));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_MUL;
            ST_MUL:      if (mul_last) n_state = ST_SQ_LOAD;
            ST_SQ_LOAD:  n_state = ST_SQRT;
            ST_SQRT:     if (mul_last) n_state = ST_DIV_LOAD;
            ST_DIV_LOAD: n_state = ST_DIV;
            ST_DIV:      if (div_last) n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_cnt      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = mul_last ? '0 : CW'(r_cnt + 1'b1);
            end
            ST_SQ_LOAD: o_cmd.sqrt_load = 1'b1;
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = mul_last ? '0 : CW'(r_cnt + 1'b1);
            end
            ST_DIV_LOAD: o_cmd.div_load = 1'b1;
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = div_last ? '0 : CW'(r_cnt + 1'b1);
            end
            ST_DONE: o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/spring_constraint_projection_top.sv
// Top level of the spring constraint projection block.
`timescale 1ns / 1ps

// Takes one spring word (two endpoints and a rest length, Q16.16) and returns
// the endpoint difference rescaled to the rest length (rest length / sqrt(2)
// in both components for a zero length), the floored length, the running
// minimum length and a zero-length flag. Three one-bit-per-cycle units run in
// turn: the shift-add multipliers for the squares and rest products, the
// bit-serial square root and the restoring dividers. One spring is in work at
// a time; the input is ready again once the result moves to the output
// register, where it waits for the sink without holding up the next spring.
module spring_constraint_projection_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spc_spring_if.sink  i_spring,
    spc_proj_if.source  o_proj
);
    import spc_pkg::*;

    t_cmd cmd;

    spc_ctrl #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_spring.valid),
        .o_in_ready  (i_spring.ready),
        .i_out_ready (o_proj.ready),
        .o_out_valid (o_proj.valid),
        .o_cmd       (cmd)
    );

    spc_datapath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_end_a_x         (i_spring.end_a_x),
        .i_end_a_y         (i_spring.end_a_y),
        .i_end_b_x         (i_spring.end_b_x),
        .i_end_b_y         (i_spring.end_b_y),
        .i_rest_length     (i_spring.rest_length),
        .o_proj_dx         (o_proj.proj_dx),
        .o_proj_dy         (o_proj.proj_dy),
        .o_spring_length   (o_proj.spring_length),
        .o_shortest_length (o_proj.shortest_length),
        .o_zero_length     (o_proj.zero_length)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_spring.valid && i_spring.ready |=> !i_spring.ready)
        else $error("input ready right after accepting a word");

    a_zero_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_proj.valid && o_proj.zero_length |->
            (o_proj.proj_dx == o_proj.proj_dy) && (o_proj.spring_length == '0))
        else $error("zero-length word with unequal components or nonzero length");

    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_proj.valid |-> o_proj.shortest_length <= o_proj.spring_length)
        else $error("shortest length exceeds current length");

    a_flag_matches_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_proj.valid && (o_proj.spring_length == '0) |-> o_proj.zero_length)
        else $error("zero length without flag");

endmodule
